// File: hdl/pwm_duty_ramp_generator_macros.svh
// Assertion macros used by the ramp generator controller.
`ifndef PWM_DUTY_RAMP_GENERATOR_MACROS_SVH
`define PWM_DUTY_RAMP_GENERATOR_MACROS_SVH

// A condition at one edge requires a consequence at the next edge.
`define PDR_ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("next-cycle check failed");

// A condition at one edge requires a consequence at the same edge.
`define PDR_ASSERT_SAME(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("same-cycle check failed");

`endif

// File: hdl/pdr_pkg.sv
package pdr_pkg;

   localparam int LEVEL_W    = 15;
   localparam int INTERVAL_W = 16;
   localparam int CMP_W      = 4;
   localparam int CH_W       = 2;
   localparam int RES_CNT_W  = 3;

   // 100 percent in Q7.8.
   localparam logic [LEVEL_W-1:0] FULL_LEVEL = 15'd25600;
   localparam int MAX_RESULTS = 4;

   // Division by 100 as multiplication by ceil(2^24 / 100), exact below 2^17.
   localparam int RECIP_W     = 18;
   localparam int RECIP_SHIFT = 24;
   localparam logic [RECIP_W-1:0] RECIP_MULT = 18'd167773;

   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_SET   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_VISIT,
      ST_FLUSH,
      ST_MUL,
      ST_DIV
   } pdr_state_type;

   typedef struct packed {
      logic load;
      logic dispatch;
      logic visit;
      logic flush;
      logic mul;
      logic div_load;
   } pdr_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic cand;
      logic hold_valid;
      logic last_idx;
      logic out_free;
   } pdr_status_type;

   function automatic logic [LEVEL_W-1:0] sat_level(input logic [LEVEL_W-1:0] v);
      return (v > FULL_LEVEL) ? FULL_LEVEL : v;
   endfunction

endpackage

// File: hdl/pdr_ctrl.sv
`include "pwm_duty_ramp_generator_macros.svh"

module pdr_ctrl
   import pdr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  pdr_status_type status,
   output pdr_cmd_type    cmd
);

   pdr_state_type state_ff, state_in;
   logic sweep_ff, sweep_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sweep_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (status.is_tick) begin
               state_in = ST_VISIT;
               sweep_in = 1'b1;
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_VISIT: begin
            if (status.last_idx) sweep_in = 1'b0;
            // A second result found pushes the held one to conversion first.
            if (status.cand && status.hold_valid) state_in = ST_MUL;
            else if (status.last_idx)             state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            state_in = status.hold_valid ? ST_MUL : ST_IDLE;
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (status.out_free) state_in = sweep_ff ? ST_VISIT : ST_FLUSH;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_DISPATCH: cmd.dispatch = 1'b1;
         ST_VISIT:    cmd.visit    = 1'b1;
         ST_FLUSH:    cmd.flush    = status.hold_valid;
         ST_MUL:      cmd.mul      = 1'b1;
         ST_DIV:      cmd.div_load = status.out_free;
         default: begin
            cmd       = '0;
            req_stall = 1'b1;
         end
      endcase
   end

   `PDR_ASSERT_NEXT(a_mul_then_div, clock, reset, state_ff == ST_MUL, state_ff == ST_DIV)
   `PDR_ASSERT_NEXT(a_push_converts, clock, reset,
      state_ff == ST_VISIT && status.cand && status.hold_valid, state_ff == ST_MUL)
   `PDR_ASSERT_NEXT(a_div_waits, clock, reset,
      state_ff == ST_DIV && !status.out_free, state_ff == ST_DIV)
   `PDR_ASSERT_SAME(a_flush_empty_done, clock, reset,
      cmd.flush, status.hold_valid && state_ff == ST_FLUSH)

endmodule

// File: hdl/pdr_dpath.sv
module pdr_dpath
   import pdr_pkg::*;
#(
   parameter int NUM_CHANNELS = 4,
   parameter int PWM_PERIOD   = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pdr_cmd_type           cmd,
   output pdr_status_type        status,
   input  logic [1:0]            req_mode,
   input  logic [CH_W-1:0]       req_motor,
   input  logic [LEVEL_W-1:0]    req_start_level,
   input  logic [LEVEL_W-1:0]    req_target_level,
   input  logic [LEVEL_W-1:0]    req_step_size,
   input  logic [INTERVAL_W-1:0] req_interval_ticks,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CH_W-1:0]       rsp_channel,
   output logic [CMP_W-1:0]      rsp_compare_value,
   output logic [LEVEL_W-1:0]    rsp_duty_level,
   output logic                  rsp_last
);

   localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int PROD_W = LEVEL_W + $clog2(PWM_PERIOD + 1);
   localparam int X_W    = PROD_W - 8;
   localparam int MULT_W = (X_W + RECIP_W > RECIP_SHIFT + CMP_W) ?
                           (X_W + RECIP_W) : (RECIP_SHIFT + CMP_W);

   // Per-channel ramp state.
   logic [LEVEL_W-1:0]    cur_ff  [NUM_CHANNELS];
   logic [LEVEL_W-1:0]    goal_ff [NUM_CHANNELS];
   logic [LEVEL_W-1:0]    step_ff [NUM_CHANNELS];
   logic [INTERVAL_W-1:0] ivl_ff  [NUM_CHANNELS];
   logic [INTERVAL_W-1:0] cnt_ff  [NUM_CHANNELS];
   logic                  act_ff  [NUM_CHANNELS];

   // Captured request.
   logic [1:0]            in_mode_ff;
   logic [CH_W-1:0]       in_motor_ff;
   logic [LEVEL_W-1:0]    in_start_ff;
   logic [LEVEL_W-1:0]    in_target_ff;
   logic [LEVEL_W-1:0]    in_step_ff;
   logic [INTERVAL_W-1:0] in_ivl_ff;

   logic [IDX_W-1:0]     idx_ff;
   logic [RES_CNT_W-1:0] res_cnt_ff;

   logic                 hold_valid_ff;
   logic [CH_W-1:0]      hold_ch_ff;
   logic [LEVEL_W-1:0]   hold_level_ff;
   logic [CH_W-1:0]      conv_ch_ff;
   logic [LEVEL_W-1:0]   conv_level_ff;
   logic                 conv_last_ff;
   logic [PROD_W-1:0]    prod_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]      rsp_channel_ff;
   logic [CMP_W-1:0]     rsp_compare_ff;
   logic [LEVEL_W-1:0]   rsp_level_ff;
   logic                 rsp_last_ff;

   logic [IDX_W-1:0]      m_idx;
   logic                  motor_ok;
   logic                  start_ok;
   logic                  set_ok;
   logic                  v_act;
   logic [INTERVAL_W-1:0] v_cnt1;
   logic                  v_due;
   logic [LEVEL_W-1:0]    v_cur;
   logic [LEVEL_W-1:0]    v_goal;
   logic [LEVEL_W-1:0]    v_step;
   logic [LEVEL_W:0]      v_sum;
   logic [LEVEL_W-1:0]    v_diff;
   logic [LEVEL_W-1:0]    v_new;
   logic                  v_stop;
   logic                  v_cand;
   logic [X_W-1:0]        quot_x;
   logic [MULT_W-1:0]     quot_mult;
   logic                  out_free;

   assign m_idx    = IDX_W'(in_motor_ff);
   assign motor_ok = (32'(in_motor_ff) < NUM_CHANNELS);
   assign start_ok = cmd.dispatch && (in_mode_ff == MODE_START) && motor_ok &&
                     (in_step_ff != '0);
   assign set_ok   = cmd.dispatch && (in_mode_ff == MODE_SET) && motor_ok;

   // Evaluation of the channel under visit.
   always_comb begin
      v_act  = act_ff[idx_ff];
      v_cnt1 = cnt_ff[idx_ff] + INTERVAL_W'(1);
      v_due  = (v_cnt1 >= ivl_ff[idx_ff]);
      v_cur  = cur_ff[idx_ff];
      v_goal = goal_ff[idx_ff];
      v_step = step_ff[idx_ff];
      v_sum  = {1'b0, v_cur} + {1'b0, v_step};
      v_diff = v_cur - v_goal;
      v_stop = 1'b0;
      if (v_cur < v_goal) begin
         v_new = (v_sum > {1'b0, v_goal}) ? v_goal : v_sum[LEVEL_W-1:0];
      end else if (v_cur > v_goal) begin
         v_new = (v_step >= v_diff) ? v_goal : (v_cur - v_step);
      end else begin
         v_new  = v_cur;
         v_stop = 1'b1;
      end
      v_cand = v_act && v_due && (res_cnt_ff < RES_CNT_W'(MAX_RESULTS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            cur_ff[i]  <= '0;
            goal_ff[i] <= '0;
            step_ff[i] <= '0;
            ivl_ff[i]  <= '0;
            cnt_ff[i]  <= '0;
            act_ff[i]  <= 1'b0;
         end
      end else if (start_ok) begin
         cur_ff[m_idx]  <= in_start_ff;
         goal_ff[m_idx] <= in_target_ff;
         step_ff[m_idx] <= in_step_ff;
         ivl_ff[m_idx]  <= in_ivl_ff;
         cnt_ff[m_idx]  <= '0;
         act_ff[m_idx]  <= 1'b1;
      end else if (cmd.visit && v_act) begin
         if (v_due) begin
            cnt_ff[idx_ff] <= '0;
            cur_ff[idx_ff] <= v_new;
            if (v_stop) act_ff[idx_ff] <= 1'b0;
         end else begin
            cnt_ff[idx_ff] <= v_cnt1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         in_mode_ff   <= req_mode;
         in_motor_ff  <= req_motor;
         in_start_ff  <= sat_level(req_start_level);
         in_target_ff <= sat_level(req_target_level);
         in_step_ff   <= req_step_size;
         in_ivl_ff    <= req_interval_ticks;
      end
   end

   // Sweep position, result count and the held result.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         res_cnt_ff    <= '0;
         hold_valid_ff <= 1'b0;
      end else begin
         if (cmd.dispatch) begin
            idx_ff     <= '0;
            res_cnt_ff <= '0;
            if (start_ok || set_ok) hold_valid_ff <= 1'b1;
         end else if (cmd.visit) begin
            idx_ff <= idx_ff + IDX_W'(1);
            if (v_cand) begin
               res_cnt_ff    <= res_cnt_ff + RES_CNT_W'(1);
               hold_valid_ff <= 1'b1;
            end
         end else if (cmd.flush) begin
            hold_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.dispatch) begin
         hold_ch_ff    <= in_motor_ff;
         hold_level_ff <= in_start_ff;
      end else if (cmd.visit && v_cand) begin
         hold_ch_ff    <= CH_W'(idx_ff);
         hold_level_ff <= v_new;
      end
      if ((cmd.visit && v_cand && hold_valid_ff) || cmd.flush) begin
         conv_ch_ff    <= hold_ch_ff;
         conv_level_ff <= hold_level_ff;
         conv_last_ff  <= cmd.flush;
      end
      if (cmd.mul) prod_ff <= PROD_W'(conv_level_ff) * PROD_W'(PWM_PERIOD);
   end

   // compare = floor(level * PWM_PERIOD / 256 / 100).
   assign quot_x    = prod_ff[PROD_W-1:8];
   assign quot_mult = MULT_W'(quot_x) * MULT_W'(RECIP_MULT);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.div_load)             rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rsp_channel_ff <= conv_ch_ff;
         rsp_compare_ff <= quot_mult[RECIP_SHIFT +: CMP_W];
         rsp_level_ff   <= conv_level_ff;
         rsp_last_ff    <= conv_last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_channel       = rsp_channel_ff;
   assign rsp_compare_value = rsp_compare_ff;
   assign rsp_duty_level    = rsp_level_ff;
   assign rsp_last          = rsp_last_ff;

   always_comb begin
      status            = '0;
      status.is_tick    = (in_mode_ff == MODE_TICK);
      status.cand       = v_cand;
      status.hold_valid = hold_valid_ff;
      status.last_idx   = (idx_ff == IDX_W'(NUM_CHANNELS - 1));
      status.out_free   = out_free;
   end

endmodule

// File: hdl/pwm_duty_ramp_generator.sv
// Four-channel PWM duty ramp generator. Duties are unsigned Q7.8 percent
// (25600 is full on). A tick (mode 0) sweeps the channels one per cycle
// while no held result is being converted, advances each active ramp's
// interval counter, steps due ramps toward their target and reports each
// stepped channel with its PWM compare value floor(duty * PWM_PERIOD /
// 25600); at most four results per tick. Mode 1 loads and starts a ramp
// and reports its start duty, mode 2 reports a duty directly. The block
// handles one request at a time, held by the channel sweep and by the
// multiply pipeline (product register, then output register) that
// converts each duty into a compare value. A finished result waits in an
// output register, so the next request is taken while it is still pending.
module pwm_duty_ramp_generator
   import pdr_pkg::*;
#(
   parameter int NUM_CHANNELS = 4,
   parameter int PWM_PERIOD   = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_mode,
   input  logic [CH_W-1:0]       req_motor,
   input  logic [LEVEL_W-1:0]    req_start_level,
   input  logic [LEVEL_W-1:0]    req_target_level,
   input  logic [LEVEL_W-1:0]    req_step_size,
   input  logic [INTERVAL_W-1:0] req_interval_ticks,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CH_W-1:0]       rsp_channel,
   output logic [CMP_W-1:0]      rsp_compare_value,
   output logic [LEVEL_W-1:0]    rsp_duty_level,
   output logic                  rsp_last
);

   pdr_cmd_type    cmd;
   pdr_status_type status;

   pdr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pdr_dpath #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .PWM_PERIOD   (PWM_PERIOD)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_mode           (req_mode),
      .req_motor          (req_motor),
      .req_start_level    (req_start_level),
      .req_target_level   (req_target_level),
      .req_step_size      (req_step_size),
      .req_interval_ticks (req_interval_ticks),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_channel        (rsp_channel),
      .rsp_compare_value  (rsp_compare_value),
      .rsp_duty_level     (rsp_duty_level),
      .rsp_last           (rsp_last)
   );

endmodule

// File: test/testbench.sv
module testbench;
   import pdr_pkg::*;

   localparam int CHANNELS = 4;
   localparam int PWM_TICKS = 10;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int FROM_PREDICTOR = -1;
   localparam int DIRECTED_N = 24;
   localparam int RANDOM_N = 480;
   localparam int QUIET_N = 60;
   localparam int PAUSE_A = 150;
   localparam int PAUSE_B = 350;
   localparam int HOLD_AT = 250;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [1:0]            mode;
      logic [CH_W-1:0]       motor;
      logic [LEVEL_W-1:0]    start_level;
      logic [LEVEL_W-1:0]    target_level;
      logic [LEVEL_W-1:0]    step_size;
      logic [INTERVAL_W-1:0] interval_ticks;
   } ramp_request_type;

   typedef struct packed {
      logic [CH_W-1:0]    channel;
      logic [CMP_W-1:0]   compare_value;
      logic [LEVEL_W-1:0] duty_level;
      logic               last;
   } duty_report_type;

   typedef struct {
      logic [1:0]            mode;
      logic [CH_W-1:0]       motor;
      logic [LEVEL_W-1:0]    start_level, target_level, step_size;
      logic [INTERVAL_W-1:0] interval_ticks;
      int                    typed_count;
      logic [CMP_W-1:0]      typed_compare;
      logic [LEVEL_W-1:0]    typed_duty;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_mode;
   logic [CH_W-1:0]       req_motor;
   logic [LEVEL_W-1:0]    req_start_level;
   logic [LEVEL_W-1:0]    req_target_level;
   logic [LEVEL_W-1:0]    req_step_size;
   logic [INTERVAL_W-1:0] req_interval_ticks;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [CH_W-1:0]       rsp_channel;
   logic [CMP_W-1:0]      rsp_compare_value;
   logic [LEVEL_W-1:0]    rsp_duty_level;
   logic                  rsp_last;

   // Own copy of the per-channel ramp state.
   logic [LEVEL_W-1:0]    duty_now [CHANNELS];
   logic [LEVEL_W-1:0]    goal_duty [CHANNELS];
   logic [LEVEL_W-1:0]    ramp_inc [CHANNELS];
   logic [INTERVAL_W-1:0] ramp_interval [CHANNELS];
   logic [INTERVAL_W-1:0] tick_cnt [CHANNELS];
   logic                  ramp_on [CHANNELS];

   duty_report_type report_buf [MAX_RESULTS];
   duty_report_type pending_reports [$];
   int           mismatches = 0;
   int           transfers_in = 0;
   logic         quiet = 1'b0;

   directed_row_type directed_rows [DIRECTED_N] = '{
      '{MODE_TICK,   2'd0, 15'd0,     15'd0,     15'd0,     16'd0,     0, 4'd0,  15'd0},
      '{MODE_SET,    2'd0, 15'd0,     15'd32767, 15'd32767, 16'd65535, 1, 4'd0,  15'd0},
      '{MODE_SET,    2'd3, 15'd25600, 15'd0,     15'd0,     16'd0,     1, 4'd10, 15'd25600},
      '{MODE_SET,    2'd1, 15'd32767, 15'd0,     15'd0,     16'd0,     1, 4'd10, 15'd25600},
      '{MODE_SET,    2'd2, 15'd2559,  15'd0,     15'd0,     16'd0,     1, 4'd0,  15'd2559},
      '{MODE_SET,    2'd2, 15'd2560,  15'd0,     15'd0,     16'd0,     1, 4'd1,  15'd2560},
      '{MODE_UNUSED, 2'd3, 15'd32767, 15'd32767, 15'd32767, 16'd65535, 0, 4'd0,  15'd0},
      '{MODE_START,  2'd1, 15'd5000,  15'd9000,  15'd0,     16'd3,     0, 4'd0,  15'd0},
      '{MODE_START,  2'd0, 15'd0,     15'd32767, 15'd32767, 16'd0,     1, 4'd0,  15'd0},
      '{MODE_START,  2'd1, 15'd32767, 15'd0,     15'd10000, 16'd1,     1, 4'd10, 15'd25600},
      '{MODE_START,  2'd2, 15'd12800, 15'd12800, 15'd1,     16'd2,     1, 4'd5,  15'd12800},
      '{MODE_START,  2'd3, 15'd100,   15'd25600, 15'd1,     16'd65535, 1, 4'd0,  15'd100},
      '{MODE_TICK,   2'd0, 15'd0,     15'd0,     15'd0,     16'd0,
        FROM_PREDICTOR, 4'd0, 15'd0},
      '{MODE_TICK,   2'd3, 15'd32767, 15'd32767, 15'd32767, 16'd65535,
        FROM_PREDICTOR, 4'd0, 15'd0},
      '{MODE_SET,    2'd1, 15'd7000,  15'd0,     15'd0,     16'd0,
        FROM_PREDICTOR, 4'd0, 15'd0},
      '{MODE_TICK,   2'd0, 15'd0,     15'd0,     15'd0,     16'd0,
        FROM_PREDICTOR, 4'd0, 15'd0},
      '{MODE_TICK,   2'd0, 15'd0,     15'd0,     15'd0,     16'd0,
        FROM_PREDICTOR, 4'd0, 15'd0},
      '{MODE_TICK,   2'd0, 15'd0,     15'd0,     15'd0,     16'd0,
        FROM_PREDICTOR, 4'd0, 15'd0},
      '{MODE_START,  2'd0, 15'd25600, 15'd0,     15'd1,     16'd0,     1, 4'd10, 15'd25600},
      '{MODE_START,  2'd1, 15'd25599, 15'd0,     15'd2,     16'd0,     1, 4'd9,  15'd25599},
      '{MODE_START,  2'd2, 15'd0,     15'd25600, 15'd3,     16'd0,     1, 4'd0,  15'd0},
      '{MODE_START,  2'd3, 15'd0,     15'd32767, 15'd1,     16'd0,     1, 4'd0,  15'd0},
      '{MODE_TICK,   2'd0, 15'd0,     15'd0,     15'd0,     16'd0,
        FROM_PREDICTOR, 4'd0, 15'd0},
      '{MODE_TICK,   2'd0, 15'd0,     15'd0,     15'd0,     16'd0,
        FROM_PREDICTOR, 4'd0, 15'd0}
   };

   pwm_duty_ramp_generator #(
      .NUM_CHANNELS(CHANNELS),
      .PWM_PERIOD(PWM_TICKS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_motor(req_motor),
      .req_start_level(req_start_level),
      .req_target_level(req_target_level),
      .req_step_size(req_step_size),
      .req_interval_ticks(req_interval_ticks),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_channel(rsp_channel),
      .rsp_compare_value(rsp_compare_value),
      .rsp_duty_level(rsp_duty_level),
      .rsp_last(rsp_last)
   );

   always #2 clock = ~clock;

   function automatic logic [LEVEL_W-1:0] limit_duty(input logic [LEVEL_W-1:0] level);
      return (level > FULL_LEVEL) ? FULL_LEVEL : level;
   endfunction

   function automatic duty_report_type make_report(input int ch,
                                                   input logic [LEVEL_W-1:0] level);
      duty_report_type d;
      int cmp;
      d.duty_level = limit_duty(level);
      cmp = (int'(d.duty_level) * PWM_TICKS) / int'(FULL_LEVEL);
      d.channel = ch[CH_W-1:0];
      d.compare_value = cmp[CMP_W-1:0];
      d.last = 1'b0;
      return d;
   endfunction

   // Applies one request to the ramp state and fills report_buf; returns the report count.
   function automatic int advance_ramps(input ramp_request_type r);
      int n;
      int i;
      logic [LEVEL_W+1:0] cur, goal, inc;
      n = 0;
      case (r.mode)
         MODE_TICK: begin
            for (i = 0; i < CHANNELS; i++) begin
               if (!ramp_on[i]) continue;
               tick_cnt[i] = tick_cnt[i] + 1'b1;
               if (tick_cnt[i] < ramp_interval[i]) continue;
               tick_cnt[i] = '0;
               cur = {2'b00, duty_now[i]};
               goal = {2'b00, goal_duty[i]};
               inc = {2'b00, ramp_inc[i]};
               if (cur < goal) begin
                  cur = cur + inc;
                  if (cur > goal) cur = goal;
               end else if (cur > goal) begin
                  cur = (inc >= cur - goal) ? goal : cur - inc;
               end else begin
                  ramp_on[i] = 1'b0;
               end
               duty_now[i] = cur[LEVEL_W-1:0];
               if (n < MAX_RESULTS) begin
                  report_buf[n] = make_report(i, duty_now[i]);
                  n++;
               end
            end
         end
         MODE_START: begin
            if (r.motor < CHANNELS && r.step_size != '0) begin
               duty_now[r.motor] = limit_duty(r.start_level);
               goal_duty[r.motor] = limit_duty(r.target_level);
               ramp_inc[r.motor] = r.step_size;
               ramp_interval[r.motor] = r.interval_ticks;
               tick_cnt[r.motor] = '0;
               ramp_on[r.motor] = 1'b1;
               report_buf[0] = make_report(int'(r.motor), r.start_level);
               n = 1;
            end
         end
         MODE_SET: begin
            if (r.motor < CHANNELS) begin
               report_buf[0] = make_report(int'(r.motor), r.start_level);
               n = 1;
            end
         end
         default: n = 0;
      endcase
      if (n > 0) report_buf[n-1].last = 1'b1;
      return n;
   endfunction

   function automatic logic [LEVEL_W-1:0] random_level();
      if ($urandom_range(0, 4) == 0) return LEVEL_W'($urandom_range(0, 32767));
      return LEVEL_W'($urandom_range(0, 25600));
   endfunction

   function automatic ramp_request_type random_request();
      ramp_request_type r;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) r.mode = MODE_TICK;
      else if (pick < 75) r.mode = MODE_START;
      else if (pick < 92) r.mode = MODE_SET;
      else r.mode = MODE_UNUSED;
      r.motor = CH_W'($urandom_range(0, CHANNELS - 1));
      r.start_level = random_level();
      r.target_level = random_level();
      pick = $urandom_range(0, 9);
      if (pick == 0) r.step_size = '0;
      else if (pick < 4) r.step_size = LEVEL_W'($urandom_range(0, 32767));
      else r.step_size = LEVEL_W'($urandom_range(1, 4000));
      // Mostly short intervals so that ramps actually step during the run.
      pick = $urandom_range(0, 9);
      if (pick < 6) r.interval_ticks = INTERVAL_W'($urandom_range(0, 3));
      else if (pick < 9) r.interval_ticks = INTERVAL_W'($urandom_range(0, 12));
      else r.interval_ticks = INTERVAL_W'($urandom_range(0, 65535));
      return r;
   endfunction

   task automatic offer_request(input ramp_request_type r, input int typed_count,
                                input duty_report_type typed);
      int n;
      int j;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= r.mode;
      req_motor <= r.motor;
      req_start_level <= r.start_level;
      req_target_level <= r.target_level;
      req_step_size <= r.step_size;
      req_interval_ticks <= r.interval_ticks;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // The transfer happened at this edge.
      transfers_in++;
      n = advance_ramps(r);
      if (typed_count == FROM_PREDICTOR) begin
         for (j = 0; j < n; j++) pending_reports.push_back(report_buf[j]);
      end else if (typed_count == 1) begin
         pending_reports.push_back(typed);
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   initial begin
      ramp_request_type r;
      duty_report_type typed;
      int k;
      int wait_cycles;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = '0;
      req_motor = '0;
      req_start_level = '0;
      req_target_level = '0;
      req_step_size = '0;
      req_interval_ticks = '0;
      for (k = 0; k < CHANNELS; k++) begin
         duty_now[k] = '0;
         goal_duty[k] = '0;
         ramp_inc[k] = '0;
         ramp_interval[k] = '0;
         tick_cnt[k] = '0;
         ramp_on[k] = 1'b0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < DIRECTED_N; k++) begin
         r = '{directed_rows[k].mode, directed_rows[k].motor, directed_rows[k].start_level,
               directed_rows[k].target_level, directed_rows[k].step_size,
               directed_rows[k].interval_ticks};
         typed = '{directed_rows[k].motor, directed_rows[k].typed_compare,
                   directed_rows[k].typed_duty, 1'b1};
         offer_request(r, directed_rows[k].typed_count, typed);
      end

      for (k = 0; k < RANDOM_N; k++) begin
         if (k == PAUSE_A || k == PAUSE_B) begin
            // Let the block drain completely before going on.
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_reports.size() != 0) @(posedge clock);
         end
         if (k == RANDOM_N - QUIET_N) quiet = 1'b1;
         offer_request(random_request(), FROM_PREDICTOR, '0);
      end
      req_valid <= 1'b0;

      for (wait_cycles = 0; wait_cycles < DRAIN_LIMIT && pending_reports.size() != 0;
           wait_cycles++)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_reports.size() != 0) begin
         $display("%0t: %0d reports missing, first expected channel %0d compare %0d duty %0d",
                  $time, pending_reports.size(), pending_reports[0].channel,
                  pending_reports[0].compare_value, pending_reports[0].duty_level);
         mismatches++;
      end
      if (mismatches == 0)
         $display("pwm_duty_ramp_generator: match");
      else
         $display("pwm_duty_ramp_generator: mismatch");
      $finish;
   end

   // Result side: random stall bursts, plus one long hold-off that backs the block up.
   initial begin
      int burst;
      logic hold_done;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && transfers_in >= HOLD_AT) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 11);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      duty_report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: no report expected, got channel %0d compare %0d duty %0d last %0d",
                     $time, rsp_channel, rsp_compare_value, rsp_duty_level, rsp_last);
            mismatches++;
         end else begin
            want = pending_reports.pop_front();
            check_field("channel", 16'(want.channel), 16'(rsp_channel));
            check_field("compare_value", 16'(want.compare_value), 16'(rsp_compare_value));
            check_field("duty_level", 16'(want.duty_level), 16'(rsp_duty_level));
            check_field("last", 16'(want.last), 16'(rsp_last));
         end
      end
   end

   initial begin
      #2000000;
      $display("pwm_duty_ramp_generator: mismatch");
      $finish;
   end

endmodule

// File: files.f
+incdir+hdl
hdl/pdr_pkg.sv
hdl/pdr_ctrl.sv
hdl/pdr_dpath.sv
hdl/pwm_duty_ramp_generator.sv
test/testbench.sv
